// ----- src/lbs_pkg.sv -----
`timescale 1ns / 1ps

package lbs_pkg;

    localparam int MAX_GROUPS       = 64;
    localparam int COORD_FRAC_BITS  = 16;
    localparam int MATRIX_FRAC_BITS = 16;

    localparam int NUM_SLOTS = MAX_GROUPS + 2;
    localparam int SLOT_IW   = $clog2(NUM_SLOTS);
    localparam int ELEMS     = 12;
    localparam int MEM_DEPTH = NUM_SLOTS * ELEMS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [3:0]  ELEM_VALID = 4'd12;
    localparam logic [3:0]  ELEM_LAST  = 4'd11;
    localparam logic [23:0] TOTAL_MAX  = 24'hFF_FFFF;
    localparam logic [63:0] QUOT_LIMIT = 64'd1 << 40;

    localparam logic signed [32:0] ONE_COORD = 33'(64'd1 << COORD_FRAC_BITS);
    localparam logic signed [63:0] ROUND_HALF = 64'(64'd1 << (MATRIX_FRAC_BITS - 1));

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_VERTEX = 2'd1,
        REQ_INFL   = 2'd2,
        REQ_NONE   = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        SEL_TO_ARM,
        SEL_TO_TGT,
        SEL_BONE
    } slot_sel_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [6:0]         matrix_slot;
        logic [3:0]         matrix_element;
        logic signed [23:0] matrix_value;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic               vert_no_influences;
        logic [7:0]         infl_group;
        logic [16:0]        infl_weight;
        logic               infl_last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               was_deformed;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       capture;
        logic       tin_from_in;
        logic       tin_from_arm;
        logic       xf_start;
        logic       xf_rd;
        logic       xf_mul;
        logic       xf_acc;
        slot_sel_t  slot_sel;
        logic [3:0] elem;
        logic       arm_from_tout;
        logic       clear_acc;
        logic [1:0] lane;
        logic       d_mul;
        logic       d_acc;
        logic       tot_acc;
        logic       set_deformed;
        logic       clr_deformed;
        logic       div_load;
        logic [1:0] div_lane;
        logic       div_step;
        logic       fix;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic no_infl;
        logic last;
        logic group_ok;
        logic total_zero;
        logic out_free;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- src/lbs_ctrl.sv -----
`timescale 1ns / 1ps

module lbs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      in_req,
    input  lbs_pkg::sts_t   sts,
    output logic            in_ready,
    output lbs_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INFL_CHK,
        S_XF_RD,
        S_XF_MUL,
        S_XF_ACC,
        S_XF_DONE,
        S_D_MUL,
        S_D_ACC,
        S_TOT,
        S_EMIT,
        S_DIV,
        S_FIX,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        JOB_VERT,
        JOB_BONE,
        JOB_EMIT
    } job_t;

    state_t              state_reg, state_next;
    job_t                job_reg, job_next;
    lbs_pkg::slot_sel_t  sel_reg, sel_next;
    logic [3:0]          elem_reg, elem_next;
    logic [1:0]          lane_reg, lane_next;
    logic [5:0]          cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        sel_next   = sel_reg;
        elem_next  = elem_reg;
        lane_next  = lane_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.slot_sel = sel_reg;
        cmd.elem     = elem_reg;
        cmd.lane     = lane_reg;
        cmd.div_lane = lane_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_req)
                        lbs_pkg::REQ_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        lbs_pkg::REQ_VERTEX:
                        begin
                            cmd.capture     = 1'b1;
                            cmd.tin_from_in = 1'b1;
                            cmd.xf_start    = 1'b1;
                            sel_next   = lbs_pkg::SEL_TO_ARM;
                            elem_next  = 4'd0;
                            job_next   = JOB_VERT;
                            state_next = S_XF_RD;
                        end
                        lbs_pkg::REQ_INFL:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_INFL_CHK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INFL_CHK:
            begin
                if (sts.group_ok)
                begin
                    cmd.tin_from_arm = 1'b1;
                    cmd.xf_start     = 1'b1;
                    sel_next   = lbs_pkg::SEL_BONE;
                    elem_next  = 4'd0;
                    job_next   = JOB_BONE;
                    state_next = S_XF_RD;
                end
                else if (sts.last)
                    state_next = S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_XF_RD:
            begin
                cmd.xf_rd  = 1'b1;
                state_next = S_XF_MUL;
            end
            S_XF_MUL:
            begin
                cmd.xf_mul = 1'b1;
                state_next = S_XF_ACC;
            end
            S_XF_ACC:
            begin
                cmd.xf_acc = 1'b1;
                if (elem_reg == lbs_pkg::ELEM_LAST)
                    state_next = S_XF_DONE;
                else
                begin
                    elem_next  = elem_reg + 4'd1;
                    state_next = S_XF_RD;
                end
            end
            S_XF_DONE:
            begin
                case (job_reg)
                    JOB_VERT:
                    begin
                        cmd.arm_from_tout = 1'b1;
                        cmd.clear_acc     = 1'b1;
                        state_next = sts.no_infl ? S_EMIT : S_IDLE;
                    end
                    JOB_BONE:
                    begin
                        lane_next  = 2'd0;
                        state_next = S_D_MUL;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_D_MUL:
            begin
                cmd.d_mul  = 1'b1;
                state_next = S_D_ACC;
            end
            S_D_ACC:
            begin
                cmd.d_acc = 1'b1;
                if (lane_reg == 2'd2)
                    state_next = S_TOT;
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_D_MUL;
                end
            end
            S_TOT:
            begin
                cmd.tot_acc = 1'b1;
                state_next  = sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (sts.total_zero)
                begin
                    cmd.clr_deformed = 1'b1;
                    cmd.tin_from_arm = 1'b1;
                    cmd.xf_start     = 1'b1;
                    sel_next   = lbs_pkg::SEL_TO_TGT;
                    elem_next  = 4'd0;
                    job_next   = JOB_EMIT;
                    state_next = S_XF_RD;
                end
                else
                begin
                    cmd.set_deformed = 1'b1;
                    cmd.div_load     = 1'b1;
                    cmd.div_lane     = 2'd0;
                    lane_next  = 2'd0;
                    cnt_next   = 6'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix = 1'b1;
                if (lane_reg == 2'd2)
                begin
                    cmd.xf_start = 1'b1;
                    sel_next   = lbs_pkg::SEL_TO_TGT;
                    elem_next  = 4'd0;
                    job_next   = JOB_EMIT;
                    state_next = S_XF_RD;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_lane = lane_reg + 2'd1;
                    lane_next    = lane_reg + 2'd1;
                    cnt_next     = 6'd0;
                    state_next   = S_DIV;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= JOB_VERT;
            sel_reg   <= lbs_pkg::SEL_TO_ARM;
            elem_reg  <= 4'd0;
            lane_reg  <= 2'd0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            sel_reg   <= sel_next;
            elem_reg  <= elem_next;
            lane_reg  <= lane_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- src/lbs_dp.sv -----
`timescale 1ns / 1ps

module lbs_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  lbs_pkg::in_item_t   in_data,
    input  lbs_pkg::cmd_t       cmd,
    input  logic                out_ready,
    output lbs_pkg::sts_t       sts,
    output logic                out_valid,
    output lbs_pkg::out_item_t  out_data
);

    lbs_pkg::in_item_t   item_reg;
    logic signed [23:0]  mem [lbs_pkg::MEM_DEPTH];
    logic signed [23:0]  mem_q_reg;
    logic [lbs_pkg::NUM_SLOTS-1:0] gvalid_reg;

    logic signed [31:0]  arm_reg  [3];
    logic signed [31:0]  tin_reg  [3];
    logic signed [31:0]  tout_reg [3];
    logic signed [63:0]  delta_reg [3];
    logic [23:0]         total_reg;
    logic signed [63:0]  acc_reg;
    logic signed [57:0]  prod_reg;
    logic [63:0]         num_reg;
    logic [23:0]         rem_reg;
    logic                deformed_reg;
    logic                out_valid_reg;
    lbs_pkg::out_item_t  out_reg;

    // matrix table write from a load request
    logic                     wr_slot_ok;
    logic [lbs_pkg::MEM_AW-1:0] wr_addr;
    logic                     mem_we;
    logic                     gv_we;

    assign wr_slot_ok = ({25'd0, in_data.matrix_slot} < 32'(lbs_pkg::NUM_SLOTS));
    assign wr_addr    = lbs_pkg::MEM_AW'(in_data.matrix_slot) * lbs_pkg::MEM_AW'(lbs_pkg::ELEMS)
                      + lbs_pkg::MEM_AW'(in_data.matrix_element);
    assign mem_we     = cmd.load && wr_slot_ok && (in_data.matrix_element < lbs_pkg::ELEM_VALID);
    assign gv_we      = cmd.load && wr_slot_ok && (in_data.matrix_element == lbs_pkg::ELEM_VALID)
                      && (in_data.matrix_slot >= 7'd2);

    // read side
    logic [lbs_pkg::SLOT_IW-1:0] gidx;
    logic [lbs_pkg::SLOT_IW-1:0] rd_slot;
    logic [lbs_pkg::MEM_AW-1:0]  rd_addr;

    assign gidx = lbs_pkg::SLOT_IW'(item_reg.infl_group) + lbs_pkg::SLOT_IW'(2);

    always_comb
    begin
        case (cmd.slot_sel)
            lbs_pkg::SEL_TO_ARM: rd_slot = lbs_pkg::SLOT_IW'(0);
            lbs_pkg::SEL_TO_TGT: rd_slot = lbs_pkg::SLOT_IW'(1);
            default:             rd_slot = gidx;
        endcase
    end

    assign rd_addr = lbs_pkg::MEM_AW'(rd_slot) * lbs_pkg::MEM_AW'(lbs_pkg::ELEMS)
                   + lbs_pkg::MEM_AW'(cmd.elem);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= in_data.matrix_value;
        if (cmd.xf_rd)
            mem_q_reg <= mem[rd_addr];
    end

    // shared multiplier: matrix entry times coordinate, or weight times bone delta
    logic [1:0]          col;
    logic [1:0]          row;
    logic signed [24:0]  mul_a;
    logic signed [32:0]  mul_b;

    assign col = cmd.elem[1:0];
    assign row = cmd.elem[3:2];

    always_comb
    begin
        if (cmd.d_mul)
        begin
            mul_a = $signed({8'd0, item_reg.infl_weight});
            mul_b = 33'(tout_reg[cmd.lane]) - 33'(arm_reg[cmd.lane]);
        end
        else
        begin
            mul_a = 25'(mem_q_reg);
            mul_b = (col == 2'd3) ? lbs_pkg::ONE_COORD : 33'(tin_reg[col]);
        end
    end

    logic signed [63:0] acc_sum;
    logic signed [63:0] row_val;
    assign acc_sum = acc_reg + 64'(prod_reg);
    assign row_val = acc_sum >>> lbs_pkg::MATRIX_FRAC_BITS;

    // saturating delta accumulation
    logic signed [64:0] dsum;
    logic signed [63:0] dsat;
    assign dsum = {delta_reg[cmd.lane][63], delta_reg[cmd.lane]} + 65'(prod_reg);

    always_comb
    begin
        if (dsum[64] != dsum[63])
            dsat = dsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            dsat = dsum[63:0];
    end

    logic [24:0] tsum;
    logic [23:0] tsat;
    assign tsum = {1'b0, total_reg} + 25'(item_reg.infl_weight);
    assign tsat = (tsum > {1'b0, lbs_pkg::TOTAL_MAX}) ? lbs_pkg::TOTAL_MAX : tsum[23:0];

    // restoring divider, one quotient bit per step
    logic signed [63:0] div_src;
    logic [63:0]        div_mag;
    logic [24:0]        rem_sh;
    logic               rem_ge;

    assign div_src = delta_reg[cmd.div_lane];
    assign div_mag = div_src[63] ? (64'd0 - div_src) : div_src;
    assign rem_sh  = {rem_reg, num_reg[63]};
    assign rem_ge  = (rem_sh >= {1'b0, total_reg});

    // apply clamped, signed quotient to the armature coordinate
    logic [63:0]        q_clamp;
    logic signed [63:0] q_signed;
    logic signed [63:0] fix_sum;

    assign q_clamp  = (num_reg > lbs_pkg::QUOT_LIMIT) ? lbs_pkg::QUOT_LIMIT : num_reg;
    assign q_signed = delta_reg[cmd.lane][63] ? -$signed(q_clamp) : $signed(q_clamp);
    assign fix_sum  = 64'(arm_reg[cmd.lane]) + q_signed;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;

        if (cmd.tin_from_in)
        begin
            tin_reg[0] <= in_data.vert_x;
            tin_reg[1] <= in_data.vert_y;
            tin_reg[2] <= in_data.vert_z;
        end
        else if (cmd.tin_from_arm)
        begin
            tin_reg[0] <= arm_reg[0];
            tin_reg[1] <= arm_reg[1];
            tin_reg[2] <= arm_reg[2];
        end
        else if (cmd.fix)
            tin_reg[cmd.lane] <= lbs_pkg::sat32(fix_sum);

        if (cmd.xf_mul || cmd.d_mul)
            prod_reg <= mul_a * mul_b;

        if (cmd.xf_start)
            acc_reg <= lbs_pkg::ROUND_HALF;
        else if (cmd.xf_acc)
        begin
            if (col == 2'd3)
            begin
                tout_reg[row] <= lbs_pkg::sat32(row_val);
                acc_reg       <= lbs_pkg::ROUND_HALF;
            end
            else
                acc_reg <= acc_sum;
        end

        if (cmd.div_load)
        begin
            num_reg <= div_mag + {41'd0, total_reg[23:1]};
            rem_reg <= 24'd0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= 24'(rem_sh - {1'b0, total_reg});
                num_reg <= {num_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[23:0];
                num_reg <= {num_reg[62:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            out_reg.out_x        <= tout_reg[0];
            out_reg.out_y        <= tout_reg[1];
            out_reg.out_z        <= tout_reg[2];
            out_reg.was_deformed <= deformed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvalid_reg    <= '0;
            total_reg     <= 24'd0;
            deformed_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                arm_reg[i]   <= 32'sd0;
                delta_reg[i] <= 64'sd0;
            end
        end
        else
        begin
            if (gv_we)
                gvalid_reg[lbs_pkg::SLOT_IW'(in_data.matrix_slot)] <= in_data.matrix_value[0];

            if (cmd.arm_from_tout)
            begin
                arm_reg[0] <= tout_reg[0];
                arm_reg[1] <= tout_reg[1];
                arm_reg[2] <= tout_reg[2];
            end

            if (cmd.d_acc)
                delta_reg[cmd.lane] <= dsat;
            if (cmd.tot_acc)
                total_reg <= tsat;

            if (cmd.set_deformed)
                deformed_reg <= 1'b1;
            else if (cmd.clr_deformed)
                deformed_reg <= 1'b0;

            if (cmd.clear_acc || cmd.out_load)
            begin
                total_reg <= 24'd0;
                for (int i = 0; i < 3; i++)
                    delta_reg[i] <= 64'sd0;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.no_infl    = item_reg.vert_no_influences;
    assign sts.last       = item_reg.infl_last;
    assign sts.group_ok   = ({1'b0, item_reg.infl_group} < 9'(lbs_pkg::MAX_GROUPS))
                          && gvalid_reg[gidx] && (item_reg.infl_weight != 17'd0);
    assign sts.total_zero = (total_reg == 24'd0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- src/linear_blend_vertex_skinning.sv -----
`timescale 1ns / 1ps

// Linear blend skinning of a vertex stream, one request at a time. A matrix
// load is written into the table as it is taken. Every 3x4 transform runs
// through one shared 25x33 multiplier, reading, multiplying and accumulating
// each matrix entry in turn. Ending a vertex with a zero total runs only the
// target transform. With a positive total a one-bit-per-cycle divider first
// divides each axis delta by the total, one axis after another. The finished
// point waits in an output register, and loads and new requests are taken
// while it is unread; a new point waits until the previous one is taken.

module linear_blend_vertex_skinning
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lbs_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lbs_pkg::out_item_t  out_data
);

    lbs_pkg::cmd_t cmd;
    lbs_pkg::sts_t sts;

    lbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_req   (in_data.req_type),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    lbs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .sts       (sts),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ----- src/lbs_chk.sv -----
`timescale 1ns / 1ps

module lbs_chk
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input lbs_pkg::in_item_t   in_data,
    input logic                out_valid,
    input logic                out_ready,
    input lbs_pkg::out_item_t  out_data
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // a load request never produces a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == lbs_pkg::REQ_LOAD) && !out_valid
        |=> !out_valid)
        else $error("result after a load request");

    // a vertex begin keeps the engine busy for its transform
    a_vertex_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == lbs_pkg::REQ_VERTEX) |=> !in_ready)
        else $error("request taken during vertex transform");

    // no result can appear the cycle after a vertex begin
    a_vertex_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == lbs_pkg::REQ_VERTEX) && !out_valid
        |=> !out_valid)
        else $error("result too early after vertex begin");

endmodule

bind linear_blend_vertex_skinning lbs_chk u_lbs_chk (.*);
